[rtl/serial_frame_receiver_defines.svh]
// Assertion macros for the serial frame receiver; the deframer uses them.
`ifndef SERIAL_FRAME_RECEIVER_DEFINES_SVH
`define SERIAL_FRAME_RECEIVER_DEFINES_SVH

// Same-cycle implication, checked on clk and disabled while rst_n is low.
`define SFR_ASSERT_IMPLY(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("serial_frame_receiver: assertion failed");

// Next-cycle implication, checked on clk and disabled while rst_n is low.
`define SFR_ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("serial_frame_receiver: assertion failed");

`endif

[rtl/sfr_pkg.sv]
// Package with the types and constants of the serial frame receiver.
`timescale 1ns / 1ps

package sfr_pkg;

    localparam logic [7:0] HDR_FIRST  = 8'h55;
    localparam logic [7:0] HDR_SECOND = 8'hAA;
    localparam logic [7:0] TAIL_BYTE  = 8'h7E;

    typedef enum logic [2:0] {
        PH_HDR1,
        PH_HDR2,
        PH_CMD,
        PH_LEN,
        PH_DATA,
        PH_SUM,
        PH_TAIL
    } phase_t;

    typedef enum logic [1:0] {
        KIND_DATA,
        KIND_ACCEPT,
        KIND_REJECT
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE,
        ERR_CHECKSUM,
        ERR_TAIL,
        ERR_ZERO_LEN
    } err_t;

    // One received byte held in the input register.
    typedef struct packed {
        logic       valid;
        logic [7:0] rx_byte;
    } in_word_t;

    // One result word.
    typedef struct packed {
        kind_t      kind;
        logic [7:0] command;
        logic [7:0] data_byte;
        logic [7:0] byte_index;
        logic [7:0] payload_length;
        err_t       error_code;
    } result_t;

endpackage

[rtl/sfr_if.sv]
// Stream interfaces for received bytes and for result words.
`timescale 1ns / 1ps

interface sfr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfr_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] command;
    logic [7:0] data_byte;
    logic [7:0] byte_index;
    logic [7:0] payload_length;
    logic [1:0] error_code;

    modport source (output valid, output kind, output command, output data_byte,
                    output byte_index, output payload_length, output error_code,
                    input ready);
    modport sink   (input valid, input kind, input command, input data_byte,
                    input byte_index, input payload_length, input error_code,
                    output ready);
endinterface

[rtl/serial_frame_receiver.sv]
// A result enters the output register at the edge where the deframer takes its byte.
// Throughput: one byte per cycle unless stalled; phase, count and sum update in a loop.
// A byte stalls only while the result register is full and a result is due.
// Reset (rst_n low, asynchronous) empties both registers and returns the parser
// to waiting for the first header byte with all frame fields cleared.
`timescale 1ns / 1ps

module serial_frame_receiver (
    input  logic      clk,
    input  logic      rst_n,
    sfr_in_if.sink    rx,
    sfr_out_if.source res
);
    import sfr_pkg::*;

    // The design is three parts in a row. The input stage registers each
    // received word. The deframer walks the frame phases (two header bytes,
    // command, length, payload, checksum, tail) and keeps the command, the
    // length, the payload count and the running 8-bit sum. The output stage
    // holds one result word for the consumer.
    //
    // The parser advances a byte when that byte needs no result or when the
    // result register can take one, so header and good checksum bytes flow
    // even while a result waits downstream. A header mismatch drops the byte
    // and restarts the search; a zero length, a wrong checksum or a bad tail
    // rejects the frame with its error code.

    in_word_t in_word;
    result_t  result;
    logic     advance;
    logic     load;
    logic     out_free;

    sfr_in_stage u_in_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .rx      (rx),
        .advance (advance),
        .word    (in_word)
    );

    sfr_deframer u_deframer (
        .clk      (clk),
        .rst_n    (rst_n),
        .word     (in_word),
        .out_free (out_free),
        .advance  (advance),
        .load     (load),
        .result   (result)
    );

    sfr_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load),
        .result   (result),
        .out_free (out_free),
        .res      (res)
    );

endmodule

[rtl/sfr_in_stage.sv]
// Input register that holds one received byte until the deframer takes it.
`timescale 1ns / 1ps

module sfr_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    sfr_in_if.sink            rx,
    input  logic              advance,
    output sfr_pkg::in_word_t word
);
    import sfr_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       take;

    // A held byte that leaves this cycle frees the register for the next one.
    assign rx.ready   = !valid_reg || advance;
    assign take       = rx.valid && rx.ready;
    assign valid_next = take || (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            byte_reg <= rx.rx_byte;
        end
    end

    assign word.valid   = valid_reg;
    assign word.rx_byte = byte_reg;

endmodule

[rtl/sfr_deframer.sv]
// Frame parser: phase machine, frame fields, checksum and result formation.
`timescale 1ns / 1ps
`include "serial_frame_receiver_defines.svh"

module sfr_deframer (
    input  logic              clk,
    input  logic              rst_n,
    input  sfr_pkg::in_word_t word,
    input  logic              out_free,
    output logic              advance,
    output logic              load,
    output sfr_pkg::result_t  result
);
    import sfr_pkg::*;

    phase_t     phase_reg;
    phase_t     phase_next;
    logic [7:0] command_reg;
    logic [7:0] command_next;
    logic [7:0] length_reg;
    logic [7:0] length_next;
    logic [7:0] count_reg;
    logic [7:0] count_next;
    logic [7:0] sum_reg;
    logic [7:0] sum_next;

    logic [7:0] b;
    logic [7:0] plen;
    logic [7:0] count_inc;
    logic [7:0] sum_add;
    logic       emit;

    assign b         = word.rx_byte;
    assign plen      = length_reg - 8'd1;
    assign count_inc = count_reg + 8'd1;
    assign sum_add   = sum_reg + b;

    // A byte that produces no result never waits for the output register.
    assign advance = word.valid && (!emit || out_free);
    assign load    = advance && emit;

    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_HDR1: phase_next = (b == HDR_FIRST) ? PH_HDR2 : PH_HDR1;
            PH_HDR2: phase_next = (b == HDR_SECOND) ? PH_CMD : PH_HDR1;
            PH_CMD:  phase_next = PH_LEN;
            PH_LEN:
            begin
                if (b == 8'd0)
                    phase_next = PH_HDR1;
                else if (b == 8'd1)
                    phase_next = PH_SUM;
                else
                    phase_next = PH_DATA;
            end
            PH_DATA: phase_next = (count_inc >= plen) ? PH_SUM : PH_DATA;
            PH_SUM:  phase_next = (b != sum_reg) ? PH_HDR1 : PH_TAIL;
            PH_TAIL: phase_next = PH_HDR1;
            default: phase_next = (b == HDR_FIRST) ? PH_HDR2 : PH_HDR1;
        endcase
    end

    always_comb
    begin
        emit                  = 1'b0;
        command_next          = command_reg;
        length_next           = length_reg;
        count_next            = count_reg;
        sum_next              = sum_reg;
        result.kind           = KIND_REJECT;
        result.command        = command_reg;
        result.data_byte      = 8'd0;
        result.byte_index     = 8'd0;
        result.payload_length = plen;
        result.error_code     = ERR_NONE;
        case (phase_reg)
            PH_CMD:
            begin
                command_next = b;
                sum_next     = b;
            end
            PH_LEN:
            begin
                length_next = b;
                count_next  = 8'd0;
                sum_next    = sum_add;
                if (b == 8'd0)
                begin
                    emit                  = 1'b1;
                    result.payload_length = 8'd0;
                    result.error_code     = ERR_ZERO_LEN;
                end
            end
            PH_DATA:
            begin
                sum_next          = sum_add;
                count_next        = count_inc;
                emit              = 1'b1;
                result.kind       = KIND_DATA;
                result.data_byte  = b;
                result.byte_index = count_reg;
            end
            PH_SUM:
            begin
                if (b != sum_reg)
                begin
                    emit              = 1'b1;
                    result.error_code = ERR_CHECKSUM;
                end
            end
            PH_TAIL:
            begin
                emit = 1'b1;
                if (b == TAIL_BYTE)
                    result.kind = KIND_ACCEPT;
                else
                    result.error_code = ERR_TAIL;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HDR1;
            command_reg <= 8'd0;
            length_reg  <= 8'd0;
            count_reg   <= 8'd0;
            sum_reg     <= 8'd0;
        end
        else if (advance)
        begin
            phase_reg   <= phase_next;
            command_reg <= command_next;
            length_reg  <= length_next;
            count_reg   <= count_next;
            sum_reg     <= sum_next;
        end
    end

    `SFR_ASSERT_IMPLY(a_err_only_on_reject,
        load && (result.kind != KIND_REJECT), result.error_code == ERR_NONE)
    `SFR_ASSERT_IMPLY(a_index_below_length,
        load && (result.kind == KIND_DATA), result.byte_index < result.payload_length)
    `SFR_ASSERT_IMPLY(a_accept_only_at_tail,
        load && (result.kind == KIND_ACCEPT), phase_reg == PH_TAIL)
    `SFR_ASSERT_IMPLY(a_stall_only_when_full,
        word.valid && !advance, !out_free)
    `SFR_ASSERT_NEXT(a_reject_restarts,
        load && (result.kind == KIND_REJECT), phase_reg == PH_HDR1)

endmodule

[rtl/sfr_out_stage.sv]
// Result register that drives the output channel.
`timescale 1ns / 1ps

module sfr_out_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  sfr_pkg::result_t result,
    output logic             out_free,
    sfr_out_if.source        res
);
    import sfr_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t word_reg;

    // The register can take a new word when empty or when its word leaves now.
    assign out_free   = !valid_reg || res.ready;
    assign valid_next = load || (valid_reg && !res.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= result;
        end
    end

    assign res.valid          = valid_reg;
    assign res.kind           = word_reg.kind;
    assign res.command        = word_reg.command;
    assign res.data_byte      = word_reg.data_byte;
    assign res.byte_index     = word_reg.byte_index;
    assign res.payload_length = word_reg.payload_length;
    assign res.error_code     = word_reg.error_code;

endmodule
